@@ design/led_pkg.sv @@
// shared constants and types for the edit distance engine
`default_nettype none

package led_pkg;

    localparam int MAX_LEN  = 128;
    localparam int SYM_BITS = 32;
    localparam int ADDR_W   = $clog2(MAX_LEN);
    localparam int CNT_W    = $clog2(MAX_LEN + 1);
    localparam int COST_W   = CNT_W;

    localparam logic [1:0] FUNC_FIRST  = 2'd0;
    localparam logic [1:0] FUNC_SECOND = 2'd1;
    localparam logic [1:0] FUNC_CALC   = 2'd2;
    localparam logic [1:0] FUNC_NONE   = 2'd3;

    // symbol store write from the loader
    typedef struct packed {
        logic                en;
        logic                sel;
        logic [ADDR_W-1:0]   addr;
        logic [SYM_BITS-1:0] data;
    } led_wr_t;

    // status of the distance sequencer
    typedef struct packed {
        logic              done;
        logic [COST_W-1:0] dist_val;
    } led_dp_stat_t;

endpackage

`default_nettype wire

@@ design/levenshtein_distance_engine_core.sv @@
// top level: item loader, utf-8 symbol packing and result register
//
//  channel   dir   handshake                      payload
//  s_axis    in    s_axis_tvalid/s_axis_tready    tuser func, tdata data_byte
//  m_axis    out   m_axis_tvalid/m_axis_tready    tdata distance, tuser overflow
//  cfg       in    cfg_valid/cfg_ready            cfg_data utf8_mode
//
// a string byte passes through S_BYTE, after S_FLUSH when a pending sequence must be committed first
// a compute passes S_START and S_WAIT, after S_FLUSH when a flush is needed, with a row state per row:
// each cell reads then writes the cost row memory
// reset clears counts, pending sequence and overflow; stores need no clearing pass
// a result waits in the output register while string bytes are still taken;
// a further compute runs but holds its result in S_DONE until that register is free
`default_nettype none

module levenshtein_distance_engine_core
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_data,       // utf8_mode
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic [1:0]  s_axis_tuser,   // [1:0] func
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [7:0] distance
    output logic [0:0]       m_axis_tuser    // [0] overflow
);
    import led_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_FLUSH = 6'b000010,
        S_BYTE  = 6'b000100,
        S_START = 6'b001000,
        S_WAIT  = 6'b010000,
        S_DONE  = 6'b100000
    } core_state_t;

    core_state_t state_reg, state_next;

    logic                utf8_mode_reg;
    logic [1:0]          func_reg, func_next;
    logic [7:0]          byte_reg, byte_next;
    logic [CNT_W-1:0]    first_count_reg, first_count_next;
    logic [CNT_W-1:0]    second_count_reg, second_count_next;
    logic [SYM_BITS-1:0] pend_sym_reg, pend_sym_next;
    logic [2:0]          pend_rem_reg, pend_rem_next;
    logic                pend_tgt_reg, pend_tgt_next;
    logic                overflow_reg, overflow_next;
    logic                out_valid_reg, out_valid_next;
    logic [7:0]          out_dist_reg, out_dist_next;
    logic                out_ovf_reg, out_ovf_next;

    logic                commit_en;
    logic                commit_sel;
    logic [SYM_BITS-1:0] commit_sym;
    logic [CNT_W-1:0]    commit_cnt;
    logic                need_flush;
    logic [3:0]          lead_len;
    logic [SYM_BITS-1:0] shifted_sym;
    logic [2:0]          rem_dec;
    logic                dp_start;
    logic                out_free;

    led_wr_t      wr;
    led_dp_stat_t dp_stat;

    function automatic logic [3:0] lead_ones(input logic [7:0] b);
        logic       run;
        logic [3:0] n;
        run = 1'b1;
        n   = '0;
        for (int k = 7; k >= 0; k--)
        begin
            if (run && b[k])
            begin
                n = n + 4'd1;
            end
            else
            begin
                run = 1'b0;
            end
        end
        return n;
    endfunction

    assign lead_len    = lead_ones(byte_reg);
    assign shifted_sym = {pend_sym_reg[SYM_BITS-9:0], byte_reg};
    assign rem_dec     = pend_rem_reg - 3'd1;
    assign out_free    = !out_valid_reg || m_axis_tready;

    assign need_flush = (pend_rem_reg != '0) &&
                        ((s_axis_tuser == FUNC_CALC) || !utf8_mode_reg ||
                         (pend_tgt_reg != s_axis_tuser[0]));

    always_comb
    begin
        state_next        = state_reg;
        func_next         = func_reg;
        byte_next         = byte_reg;
        pend_sym_next     = pend_sym_reg;
        pend_rem_next     = pend_rem_reg;
        pend_tgt_next     = pend_tgt_reg;
        commit_en         = 1'b0;
        commit_sel        = 1'b0;
        commit_sym        = '0;
        dp_start          = 1'b0;
        out_valid_next    = out_valid_reg && !m_axis_tready;
        out_dist_next     = out_dist_reg;
        out_ovf_next      = out_ovf_reg;
        first_count_next  = first_count_reg;
        second_count_next = second_count_reg;
        overflow_next     = overflow_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    func_next = s_axis_tuser;
                    byte_next = s_axis_tdata;
                    if (s_axis_tuser == FUNC_NONE)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (need_flush)
                    begin
                        state_next = S_FLUSH;
                    end
                    else if (s_axis_tuser == FUNC_CALC)
                    begin
                        state_next = S_START;
                    end
                    else
                    begin
                        state_next = S_BYTE;
                    end
                end
            end
            S_FLUSH:
            begin
                // incomplete sequence goes in as it stands
                commit_en     = 1'b1;
                commit_sel    = pend_tgt_reg;
                commit_sym    = pend_sym_reg;
                pend_rem_next = '0;
                pend_sym_next = '0;
                state_next    = (func_reg == FUNC_CALC) ? S_START : S_BYTE;
            end
            S_BYTE:
            begin
                if (!utf8_mode_reg)
                begin
                    commit_en  = 1'b1;
                    commit_sel = func_reg[0];
                    commit_sym = {{(SYM_BITS-8){1'b0}}, byte_reg};
                end
                else if (pend_rem_reg != '0)
                begin
                    pend_rem_next = rem_dec;
                    if (rem_dec == '0)
                    begin
                        commit_en     = 1'b1;
                        commit_sel    = pend_tgt_reg;
                        commit_sym    = shifted_sym;
                        pend_sym_next = '0;
                    end
                    else
                    begin
                        pend_sym_next = shifted_sym;
                    end
                end
                else if (lead_len > 4'd1)
                begin
                    pend_sym_next = {{(SYM_BITS-8){1'b0}}, byte_reg};
                    pend_rem_next = 3'(lead_len - 4'd1);
                    pend_tgt_next = func_reg[0];
                end
                else
                begin
                    commit_en  = 1'b1;
                    commit_sel = func_reg[0];
                    commit_sym = {{(SYM_BITS-8){1'b0}}, byte_reg};
                end
                state_next = S_IDLE;
            end
            S_START:
            begin
                dp_start   = 1'b1;
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (dp_stat.done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_dist_next  = dp_stat.dist_val;
                    out_ovf_next   = overflow_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // one commit at most per cycle; a full string drops the symbol
        commit_cnt = commit_sel ? second_count_reg : first_count_reg;
        wr.en      = 1'b0;
        wr.sel     = commit_sel;
        wr.addr    = commit_cnt[ADDR_W-1:0];
        wr.data    = commit_sym;
        if (commit_en)
        begin
            if (commit_cnt >= CNT_W'(MAX_LEN))
            begin
                overflow_next = 1'b1;
            end
            else
            begin
                wr.en = 1'b1;
                if (commit_sel)
                begin
                    second_count_next = second_count_reg + CNT_W'(1);
                end
                else
                begin
                    first_count_next = first_count_reg + CNT_W'(1);
                end
            end
        end

        if ((state_reg == S_DONE) && out_free)
        begin
            first_count_next  = '0;
            second_count_next = '0;
            overflow_next     = 1'b0;
            pend_sym_next     = '0;
            pend_rem_next     = '0;
            pend_tgt_next     = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            utf8_mode_reg    <= 1'b1;
            first_count_reg  <= '0;
            second_count_reg <= '0;
            pend_sym_reg     <= '0;
            pend_rem_reg     <= '0;
            pend_tgt_reg     <= 1'b0;
            overflow_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            first_count_reg  <= first_count_next;
            second_count_reg <= second_count_next;
            pend_sym_reg     <= pend_sym_next;
            pend_rem_reg     <= pend_rem_next;
            pend_tgt_reg     <= pend_tgt_next;
            overflow_reg     <= overflow_next;
            out_valid_reg    <= out_valid_next;
            if (cfg_valid)
            begin
                utf8_mode_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg     <= func_next;
        byte_reg     <= byte_next;
        out_dist_reg <= out_dist_next;
        out_ovf_reg  <= out_ovf_next;
    end

    led_dp u_dp
    (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (wr),
        .start (dp_start),
        .len_a (first_count_reg),
        .len_b (second_count_reg),
        .stat  (dp_stat)
    );

    assign cfg_ready       = 1'b1;
    assign s_axis_tready   = (state_reg == S_IDLE);
    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_dist_reg;
    assign m_axis_tuser[0] = out_ovf_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (first_count_reg <= CNT_W'(MAX_LEN)) && (second_count_reg <= CNT_W'(MAX_LEN)))
        else $error("symbol count above capacity");

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        dp_stat.done |-> (state_reg == S_WAIT))
        else $error("distance ready outside compute wait");

    a_clear_after_result: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_DONE) && out_free) |=>
            (first_count_reg == '0 && second_count_reg == '0 &&
             pend_rem_reg == '0 && !overflow_reg && out_valid_reg))
        else $error("strings not cleared after a result");
`endif

endmodule

`default_nettype wire

@@ design/led_dp.sv @@
// symbol stores, cost row memory and the cell-by-cell distance sequencer
`default_nettype none

module led_dp
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire led_pkg::led_wr_t            wr,
    input  wire logic                        start,
    input  wire logic [led_pkg::CNT_W-1:0]   len_a,
    input  wire logic [led_pkg::CNT_W-1:0]   len_b,
    output led_pkg::led_dp_stat_t            stat
);
    import led_pkg::*;

    typedef enum logic [4:0] {
        D_IDLE = 5'b00001,
        D_ROW  = 5'b00010,
        D_READ = 5'b00100,
        D_CALC = 5'b01000,
        D_DONE = 5'b10000
    } dp_state_t;

    dp_state_t state_reg, state_next;

    logic [SYM_BITS-1:0] a_mem [MAX_LEN];
    logic [SYM_BITS-1:0] b_mem [MAX_LEN];
    logic [COST_W-1:0]   cost_mem [MAX_LEN];

    logic [SYM_BITS-1:0] a_rd_reg;
    logic [SYM_BITS-1:0] b_rd_reg;
    logic [COST_W-1:0]   cost_rd_reg;

    logic [CNT_W-1:0]  i_reg, i_next;
    logic [CNT_W-1:0]  j_reg, j_next;
    logic [CNT_W-1:0]  na_reg, na_next;
    logic [CNT_W-1:0]  nb_reg, nb_next;
    logic [COST_W-1:0] left_reg, left_next;
    logic [COST_W-1:0] diag_reg, diag_next;
    logic [COST_W-1:0] dist_reg, dist_next;

    logic [CNT_W-1:0]  i_m1;
    logic [CNT_W-1:0]  j_m1;
    logic [COST_W-1:0] up;
    logic [COST_W-1:0] min3;
    logic [COST_W-1:0] cell_cost;
    logic              cost_we;

    assign i_m1 = i_reg - CNT_W'(1);
    assign j_m1 = j_reg - CNT_W'(1);

    // first row reads the implicit initial row, cost_row[j] = j
    assign up = (i_reg == CNT_W'(1)) ? j_reg : cost_rd_reg;

    always_comb
    begin
        min3 = diag_reg;
        if (up < min3)
        begin
            min3 = up;
        end
        if (left_reg < min3)
        begin
            min3 = left_reg;
        end
        cell_cost = (a_rd_reg == b_rd_reg) ? diag_reg : min3 + COST_W'(1);
    end

    assign cost_we = (state_reg == D_CALC);

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        na_next    = na_reg;
        nb_next    = nb_reg;
        left_next  = left_reg;
        diag_next  = diag_reg;
        dist_next  = dist_reg;
        unique case (state_reg)
            D_IDLE:
            begin
                if (start)
                begin
                    na_next = len_a;
                    nb_next = len_b;
                    i_next  = CNT_W'(1);
                    if (len_a == '0)
                    begin
                        dist_next  = len_b;
                        state_next = D_DONE;
                    end
                    else if (len_b == '0)
                    begin
                        dist_next  = len_a;
                        state_next = D_DONE;
                    end
                    else
                    begin
                        state_next = D_ROW;
                    end
                end
            end
            D_ROW:
            begin
                // cost_row[0] moves from i-1 to i
                j_next     = CNT_W'(1);
                left_next  = i_reg;
                diag_next  = i_m1;
                state_next = D_READ;
            end
            D_READ:
            begin
                state_next = D_CALC;
            end
            D_CALC:
            begin
                left_next = cell_cost;
                diag_next = up;
                if (j_reg == nb_reg)
                begin
                    if (i_reg == na_reg)
                    begin
                        dist_next  = cell_cost;
                        state_next = D_DONE;
                    end
                    else
                    begin
                        i_next     = i_reg + CNT_W'(1);
                        state_next = D_ROW;
                    end
                end
                else
                begin
                    j_next     = j_reg + CNT_W'(1);
                    state_next = D_READ;
                end
            end
            D_DONE:
            begin
                state_next = D_IDLE;
            end
            default:
            begin
                state_next = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg    <= i_next;
        j_reg    <= j_next;
        na_reg   <= na_next;
        nb_reg   <= nb_next;
        left_reg <= left_next;
        diag_reg <= diag_next;
        dist_reg <= dist_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr.en && !wr.sel)
        begin
            a_mem[wr.addr] <= wr.data;
        end
        if (state_reg == D_ROW)
        begin
            a_rd_reg <= a_mem[i_m1[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en && wr.sel)
        begin
            b_mem[wr.addr] <= wr.data;
        end
        if (state_reg == D_READ)
        begin
            b_rd_reg <= b_mem[j_m1[ADDR_W-1:0]];
        end
    end

    // previous row entry is read in D_READ, before D_CALC overwrites the same entry
    always_ff @(posedge clk)
    begin
        if (cost_we)
        begin
            cost_mem[j_m1[ADDR_W-1:0]] <= cell_cost;
        end
        if (state_reg == D_READ)
        begin
            cost_rd_reg <= cost_mem[j_m1[ADDR_W-1:0]];
        end
    end

    assign stat.done     = (state_reg == D_DONE);
    assign stat.dist_val = dist_reg;

`ifndef ASSERT_OFF
    a_cell_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == D_CALC) |-> (i_reg != '0 && i_reg <= na_reg &&
                                   j_reg != '0 && j_reg <= nb_reg))
        else $error("cell index outside the string lengths");

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> (state_reg == D_IDLE))
        else $error("start while the sequencer is busy");

    a_dist_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stat.done |-> (dist_reg <= COST_W'(MAX_LEN)))
        else $error("distance above string capacity");
`endif

endmodule

`default_nettype wire

@@ tb/led_distance_checker.sv @@
// checker for the edit distance engine: predicts each result and compares it with the output
`timescale 1ns / 1ps

module led_distance_checker
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic        cfg_data,       // utf8_mode
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic [1:0]  s_axis_tuser,   // [1:0] func
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [7:0]  m_axis_tdata,   // [7:0] distance
    input  wire logic [0:0]  m_axis_tuser,   // [0] overflow
    output int               failures,
    output int               outstanding
);
    import led_pkg::*;

    typedef struct packed {
        logic [7:0] distance;
        logic       overflow;
    } dist_result_t;

    logic [SYM_BITS-1:0] first_syms  [MAX_LEN];
    logic [SYM_BITS-1:0] second_syms [MAX_LEN];
    int                  first_len;
    int                  second_len;
    logic [SYM_BITS-1:0] partial_sym;
    int                  bytes_left;
    logic                partial_sel;
    logic                dropped;
    logic                utf8_on;
    dist_result_t        expected_distances [$];

    function automatic int lead_ones(input logic [7:0] b);
        int n;
        n = 0;
        while (n < 8 && b[7 - n])
            n++;
        return n;
    endfunction

    // a full string drops the symbol and remembers it
    task automatic store_symbol(input logic sel, input logic [SYM_BITS-1:0] sym);
        if (sel)
        begin
            if (second_len >= MAX_LEN)
                dropped = 1'b1;
            else
            begin
                second_syms[second_len] = sym;
                second_len++;
            end
        end
        else
        begin
            if (first_len >= MAX_LEN)
                dropped = 1'b1;
            else
            begin
                first_syms[first_len] = sym;
                first_len++;
            end
        end
    endtask

    task automatic flush_partial();
        if (bytes_left != 0)
        begin
            store_symbol(partial_sel, partial_sym);
            bytes_left  = 0;
            partial_sym = '0;
        end
    endtask

    function automatic int edit_distance();
        int row [0:MAX_LEN];
        int diag;
        int up;
        int best;
        for (int j = 0; j <= second_len; j++)
            row[j] = j;
        for (int i = 1; i <= first_len; i++)
        begin
            diag   = row[0];
            row[0] = i;
            for (int j = 1; j <= second_len; j++)
            begin
                up = row[j];
                if (first_syms[i - 1] == second_syms[j - 1])
                    row[j] = diag;
                else
                begin
                    best = diag;
                    if (up < best)
                        best = up;
                    if (row[j - 1] < best)
                        best = row[j - 1];
                    row[j] = best + 1;
                end
                diag = up;
            end
        end
        return row[second_len];
    endfunction

    task automatic track_item(input logic [1:0] func, input logic [7:0] b);
        dist_result_t res;
        int           d;
        int           n;
        case (func)
            FUNC_NONE:
                ;
            FUNC_CALC:
            begin
                flush_partial();
                d            = edit_distance();
                res.distance = 8'(d > 255 ? 255 : d);
                res.overflow = dropped;
                expected_distances.insert(expected_distances.size(), res);
                first_len   = 0;
                second_len  = 0;
                dropped     = 1'b0;
                partial_sym = '0;
                bytes_left  = 0;
                partial_sel = 1'b0;
            end
            default:
            begin
                if (!utf8_on)
                begin
                    flush_partial();
                    store_symbol(func == FUNC_SECOND, SYM_BITS'(b));
                end
                else
                begin
                    // a byte for the other string ends the open sequence as it stands
                    if (bytes_left != 0 && partial_sel != (func == FUNC_SECOND))
                        flush_partial();
                    if (bytes_left != 0)
                    begin
                        partial_sym = {partial_sym[SYM_BITS-9:0], b};
                        bytes_left--;
                        if (bytes_left == 0)
                        begin
                            store_symbol(partial_sel, partial_sym);
                            partial_sym = '0;
                        end
                    end
                    else
                    begin
                        n = lead_ones(b);
                        if (n > 1)
                        begin
                            partial_sym = SYM_BITS'(b);
                            bytes_left  = n - 1;
                            partial_sel = (func == FUNC_SECOND);
                        end
                        else
                            store_symbol(func == FUNC_SECOND, SYM_BITS'(b));
                    end
                end
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        dist_result_t want;
        if (!rst_n)
        begin
            first_len   = 0;
            second_len  = 0;
            partial_sym = '0;
            bytes_left  = 0;
            partial_sel = 1'b0;
            dropped     = 1'b0;
            utf8_on     = 1'b1;
            expected_distances.delete();
            failures    <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                utf8_on = cfg_data;
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_distances.size() == 0)
                begin
                    $error("distance: no result expected, got %0d", m_axis_tdata);
                    failures <= failures + 1;
                end
                else
                begin
                    want = expected_distances.pop_front();
                    if (m_axis_tdata !== want.distance || m_axis_tuser[0] !== want.overflow)
                        failures <= failures + 1;
                    if (m_axis_tdata !== want.distance)
                        $error("distance: expected %0d, got %0d", want.distance, m_axis_tdata);
                    if (m_axis_tuser[0] !== want.overflow)
                        $error("overflow: expected %0d, got %0d", want.overflow,
                               m_axis_tuser[0]);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                track_item(s_axis_tuser, s_axis_tdata);
            outstanding <= expected_distances.size();
        end
    end

endmodule

@@ tb/tb_levenshtein_distance_engine_core.sv @@
// testbench top for the edit distance engine: stimulus, idling, long stalls and verdict
`timescale 1ns / 1ps

module tb_levenshtein_distance_engine_core;
    import led_pkg::*;

    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES   = 400;
    localparam int ITEM_TARGET   = 1650;
    localparam int PHASES        = 6;

    logic       clk           = 1'b0;
    logic       rst_n         = 1'b0;
    logic       cfg_valid     = 1'b0;
    logic       cfg_ready;
    logic       cfg_data      = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'h00;
    logic [1:0] s_axis_tuser  = FUNC_NONE;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic [0:0] m_axis_tuser;

    int failures;
    int outstanding;
    int cycles     = 0;
    int snd_idle   = 0;
    int rcv_idle   = 0;
    int hold_req   = 0;
    int hold_done  = 0;
    int hold_left  = 0;
    int sent       = 0;
    bit utf8_now   = 1'b1;

    logic [7:0] word_a [$];
    logic [7:0] word_b [$];

    levenshtein_distance_engine_core dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    led_distance_checker u_check
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .failures      (failures),
        .outstanding   (outstanding)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // receiver: random stalls, plus one long hold-off when asked
    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (hold_left > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end
        else if (hold_req != hold_done)
        begin
            m_axis_tready <= 1'b0;
            hold_done     <= hold_req;
            hold_left     <= HOLD_CYCLES;
        end
        else
            m_axis_tready <= ($urandom_range(0, 99) >= rcv_idle);
    end

    task automatic send_item(input logic [1:0] f, input logic [7:0] b);
        while ($urandom_range(0, 99) < snd_idle)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= f;
        s_axis_tdata  <= b;
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (f != FUNC_NONE)
            sent++;
    endtask

    // wait for every result, then let the last string byte settle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_mode(input logic v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        utf8_now = v;
    endtask

    // one symbol: mostly a small alphabet so strings share symbols
    task automatic add_symbol(input bit to_b, input bit plain);
        logic [7:0] sym_bytes [$];
        logic [7:0] lead;
        int         pick;
        int         len;
        pick = plain ? 0 : $urandom_range(0, 99);
        if (pick < 70)
            sym_bytes.insert(sym_bytes.size(), 8'h61 + 8'($urandom_range(0, 4)));
        else if (utf8_now && pick < 90)
        begin
            len  = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 8) : $urandom_range(2, 4);
            lead = 8'hFF << (8 - len);
            sym_bytes.insert(sym_bytes.size(),
                             lead | (8'($urandom) & (8'hFF >> (len + 1))));
            for (int k = 1; k < len; k++)
                sym_bytes.insert(sym_bytes.size(), 8'h80 | 8'($urandom_range(0, 63)));
        end
        else
            sym_bytes.insert(sym_bytes.size(), 8'($urandom_range(0, 255)));
        foreach (sym_bytes[k])
        begin
            if (to_b)
                word_b.insert(word_b.size(), sym_bytes[k]);
            else
                word_a.insert(word_a.size(), sym_bytes[k]);
        end
    endtask

    task automatic build_pair();
        bit long_word;
        int n;
        int pos;
        word_a.delete();
        word_b.delete();
        long_word = ($urandom_range(0, 99) < 2);
        n = long_word ? $urandom_range(126, 134) : $urandom_range(0, 9);
        while (word_a.size() < n)
            add_symbol(1'b0, long_word);
        if ($urandom_range(0, 99) < 70)
        begin
            // near miss: a few edits of the first word
            word_b = word_a;
            repeat ($urandom_range(0, 3))
            begin
                pos = $urandom_range(0, word_b.size());
                case ($urandom_range(0, 2))
                    0: word_b.insert(pos, 8'h61 + 8'($urandom_range(0, 4)));
                    1: if (pos < word_b.size()) word_b.delete(pos);
                    default: if (pos < word_b.size()) word_b[pos] = 8'($urandom);
                endcase
            end
        end
        else
        begin
            long_word = ($urandom_range(0, 99) < 3);
            n = long_word ? $urandom_range(126, 134) : $urandom_range(0, 9);
            while (word_b.size() < n)
                add_symbol(1'b1, long_word);
        end
    endtask

    // mostly first word then second; sometimes interleaved, which breaks sequences
    task automatic send_pair();
        int ia;
        int ib;
        bit mix;
        ia  = 0;
        ib  = 0;
        mix = ($urandom_range(0, 99) < 20);
        while (ia < word_a.size() || ib < word_b.size())
        begin
            if (ib >= word_b.size() ||
                (ia < word_a.size() && (!mix || $urandom_range(0, 1) == 1)))
            begin
                send_item(FUNC_FIRST, word_a[ia]);
                ia++;
            end
            else
            begin
                send_item(FUNC_SECOND, word_b[ib]);
                ib++;
            end
            if ($urandom_range(0, 99) < 3)
                send_item(FUNC_NONE, 8'($urandom));
        end
        send_item(FUNC_CALC, 8'($urandom));
    endtask

    initial
    begin
        int target;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_mode(1'b1);

        send_item(FUNC_CALC, 8'h00);       // both strings empty
        send_item(FUNC_FIRST, 8'h00);
        send_item(FUNC_FIRST, 8'h6B);
        send_item(FUNC_SECOND, 8'h7F);
        send_item(FUNC_SECOND, 8'h6B);
        send_item(FUNC_CALC, 8'hFF);
        // sequence left open at compute
        send_item(FUNC_FIRST, 8'hE2);
        send_item(FUNC_FIRST, 8'h82);
        send_item(FUNC_FIRST, 8'hAC);
        send_item(FUNC_SECOND, 8'hE2);
        send_item(FUNC_SECOND, 8'h82);
        send_item(FUNC_NONE, 8'h55);
        send_item(FUNC_CALC, 8'h00);
        // byte for the other string mid-sequence, stray continuation byte
        send_item(FUNC_FIRST, 8'hC3);
        send_item(FUNC_SECOND, 8'h41);
        send_item(FUNC_SECOND, 8'h80);
        send_item(FUNC_CALC, 8'h00);
        send_item(FUNC_FIRST, 8'hFF);
        send_item(FUNC_SECOND, 8'h00);
        send_item(FUNC_CALC, 8'h00);
        // mode switched to raw bytes while a sequence is open
        send_item(FUNC_FIRST, 8'hF0);
        drain();
        write_mode(1'b0);
        send_item(FUNC_FIRST, 8'h41);
        send_item(FUNC_SECOND, 8'h41);
        send_item(FUNC_CALC, 8'h00);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            drain();
            snd_idle = (phase < 2) ? 14 : (phase < 4) ? 74 : 0;
            rcv_idle <= (phase < 2) ? 74 : (phase < 4) ? 14 : 0;
            write_mode(phase % 2 == 0);
            if (phase == 0)
                hold_req <= hold_req + 1;
            target = sent + ITEM_TARGET / PHASES;
            while (sent < target)
            begin
                build_pair();
                send_pair();
            end
        end

        drain();
        if (failures == 0 && outstanding == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
